/* hw/rtl/stlf_pkg.sv */
// Package with shared types and constants of the store-to-load forwarding search.
`timescale 1ns / 1ps
package stlf_pkg;
    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned MASK_W      = 16;

    typedef enum logic [2:0] {
        K_ALLOC  = 3'd0,
        K_ADDR   = 3'd1,
        K_DATA   = 3'd2,
        K_FREE   = 3'd3,
        K_LOOKUP = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_FWD  = 2'd1,
        ST_WAIT = 2'd2
    } t_status;

    // Token passed along the search chain.
    typedef struct packed {
        logic        done;
        logic [1:0]  status;
        logic [4:0]  src;
    } t_token;

    // Byte lanes of an access inside its doubleword.
    function automatic logic [14:0] byte_lanes(input logic [2:0] off, input logic [1:0] sz);
        logic [7:0] base;
        base = 8'b0;
        case (sz)
            2'd0: base = 8'h01;
            2'd1: base = 8'h03;
            2'd2: base = 8'h0f;
            default: base = 8'hff;
        endcase
        byte_lanes = {7'b0, base} << off;
    endfunction
endpackage

/* hw/rtl/stlf_cell.sv */
// One search cell: checks one store queue entry and passes the token on.
`timescale 1ns / 1ps
module stlf_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  stlf_pkg::t_token      i_tok,
    input  logic                  i_elig,
    input  logic                  i_barrier,
    input  logic                  i_known,
    input  logic                  i_virt,
    input  logic                  i_rdy,
    input  logic [63:0]           i_st_addr,
    input  logic [1:0]            i_st_size,
    input  logic [63:0]           i_ld_addr,
    input  logic [1:0]            i_ld_size,
    input  logic [4:0]            i_idx,
    output stlf_pkg::t_token      o_tok
);
    import stlf_pkg::*;
    t_token      n_tok;
    t_token      r_tok;
    logic [14:0] w_ll;
    logic [14:0] w_common;

    always_comb begin
        w_ll     = byte_lanes(i_ld_addr[2:0], i_ld_size);
        w_common = w_ll & byte_lanes(i_st_addr[2:0], i_st_size);
        n_tok    = i_tok;
        if (!i_tok.done && i_elig) begin
            if (i_barrier) begin
                n_tok.done = 1'b1;
                n_tok.status = ST_WAIT;
            end else if (i_known && !i_virt && i_st_addr[63:3] == i_ld_addr[63:3]
                         && w_common != 15'b0) begin
                n_tok.done = 1'b1;
                if (w_common != w_ll || !i_rdy) begin
                    n_tok.status = ST_WAIT;
                end else begin
                    n_tok.status = ST_FWD;
                    n_tok.src = i_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end
    assign o_tok = r_tok;
endmodule

/* hw/rtl/store_to_load_forward_search.sv */
// Top level of the store queue with its store-to-load forwarding search.
// A lookup result is registered in r_out once the search has visited all entries. Only one
// lookup is searched at a time; a finished search waits only while an earlier result is
// still on the output. Queue updates are accepted one per cycle while no search is running.
// The token visits one entry per cycle as it circles the chain of CELLS cells.
// Reset (synchronous, active low) clears all entry flags but r_bar, and the control state.
`timescale 1ns / 1ps
module store_to_load_forward_search #(
    parameter int unsigned ENTRIES = stlf_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low to high: entry_index[3:0], access_address[67:4], access_size[69:68],
    // barrier_flag[70], address_is_virtual[71], older_store_mask[87:72],
    // store_tail[91:88], zero fill to 96 bits.
    input  logic [95:0] s_axis_tdata,
    // tuser: kind[2:0].
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low to high: status[1:0], source_entry[5:2], zero fill to 8 bits.
    output logic [7:0]  m_axis_tdata
);
    import stlf_pkg::*;

    // Four cells; each entry's turn comes in one of ENTRIES/4 rounds (rounded up).
    localparam int unsigned CELLS  = 4;
    localparam int unsigned ROUNDS = (ENTRIES + CELLS - 1) / CELLS;
    localparam int unsigned RW     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int unsigned PW     = $clog2(CELLS);
    localparam int unsigned IW     = $clog2(ENTRIES);
    localparam int unsigned AW     = IW + 3;

    logic [3:0]  w_idx;
    logic [63:0] w_addr;
    logic [1:0]  w_size;
    logic        w_bar;
    logic        w_virt;
    logic [15:0] w_mask;
    logic [3:0]  w_young;
    logic        w_acc;
    t_kind       w_kind;

    assign w_idx   = s_axis_tdata[3:0];
    assign w_addr  = s_axis_tdata[67:4];
    assign w_size  = s_axis_tdata[69:68];
    assign w_bar   = s_axis_tdata[70];
    assign w_virt  = s_axis_tdata[71];
    assign w_mask  = s_axis_tdata[87:72];
    assign w_young = s_axis_tdata[91:88];
    assign w_kind  = t_kind'(s_axis_tuser);

    // The store tail is reduced modulo ENTRIES through a small constant table.
    logic [IW-1:0] w_ymod [16];
    genvar t;
    generate
        for (t = 0; t < 16; t++) begin : g_ymod
            assign w_ymod[t] = IW'(t % ENTRIES);
        end
    endgenerate

    // Entry state. Flags but r_bar are reset; payload is written on allocate or address write.
    logic [ENTRIES-1:0] r_valid, r_known, r_virt, r_rdy, r_bar;
    logic [63:0]        r_eaddr [ENTRIES];
    logic [1:0]         r_esize [ENTRIES];

    // Lookup control: a search is busy while r_busy is set; r_last marks that the
    // final token sits in the last cell. The result waits in r_out.
    logic          r_busy;
    logic          r_last;
    logic [RW-1:0] r_round;
    logic [PW-1:0] r_phase;
    logic [63:0]   r_laddr;
    logic [1:0]    r_lsize;
    logic [15:0]   r_lmask;
    logic [IW-1:0] r_ly;
    logic          r_ovalid;
    logic [5:0]    r_out;
    logic          w_fin;

    // Only a running search closes the input; a waiting result does not.
    assign s_axis_tready = !r_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    // The search hands its token to the output register once that register is free.
    assign w_fin = r_busy && r_last && (!r_ovalid || m_axis_tready);

    // The search token circles the cells in a ring. In each cycle exactly one cell,
    // the one selected by r_phase, examines an entry; the others pass tokens on.
    // Cell c in round r examines age r*CELLS + c + 1.
    t_token w_tok [CELLS+1];
    logic   w_adv;
    logic   w_first;
    assign w_adv   = r_busy && !r_last;
    assign w_first = (r_round == '0) && (r_phase == '0);

    genvar c;
    generate
        for (c = 0; c < CELLS; c++) begin : g_cell
            logic [AW-1:0] w_age;
            logic [AW-1:0] w_sum;
            logic [IW-1:0] w_ei;
            logic          w_inr;
            logic          w_act;
            logic          w_el;
            assign w_act = (r_phase == PW'(c));
            assign w_age = AW'(r_round) * AW'(CELLS) + AW'(c + 1);
            assign w_inr = (w_age <= AW'(ENTRIES));
            assign w_sum = AW'(r_ly) + AW'(ENTRIES) - w_age;
            assign w_ei  = (w_sum >= AW'(ENTRIES)) ?
                           IW'(w_sum - AW'(ENTRIES)) : IW'(w_sum);
            assign w_el  = w_act && w_inr && (32'(w_ei) < MASK_W) && r_valid[w_ei]
                           && r_lmask[4'(w_ei)];
            stlf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_adv     (w_adv),
                .i_tok     (w_tok[c]),
                .i_elig    (w_el),
                .i_barrier (r_bar[w_ei]),
                .i_known   (r_known[w_ei]),
                .i_virt    (r_virt[w_ei]),
                .i_rdy     (r_rdy[w_ei]),
                .i_st_addr (r_eaddr[w_ei]),
                .i_st_size (r_esize[w_ei]),
                .i_ld_addr (r_laddr),
                .i_ld_size (r_lsize),
                .i_idx     (5'(w_ei)),
                .o_tok     (w_tok[c+1])
            );
        end
    endgenerate

    // A fresh token enters cell 0 on the first step; later rounds take the token
    // back from the last cell.
    assign w_tok[0] = w_first ? t_token'('0) : w_tok[CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
            r_round  <= '0;
            r_phase  <= '0;
            r_valid  <= '0;
            r_known  <= '0;
            r_virt   <= '0;
            r_rdy    <= '0;
        end else begin
            if (w_fin) begin
                r_ovalid <= 1'b1;
                r_out    <= w_tok[CELLS].done ?
                            {w_tok[CELLS].src[3:0], w_tok[CELLS].status} : 6'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_acc) begin
                if (w_kind == K_LOOKUP) begin
                    r_busy  <= 1'b1;
                    r_last  <= 1'b0;
                    r_round <= '0;
                    r_phase <= '0;
                    r_laddr <= w_addr;
                    r_lsize <= w_size;
                    r_lmask <= w_mask;
                    r_ly    <= w_ymod[w_young];
                end else if (32'(w_idx) < ENTRIES) begin
                    unique case (w_kind)
                        K_ALLOC: begin
                            r_valid[IW'(w_idx)] <= 1'b1;
                            r_known[IW'(w_idx)] <= 1'b0;
                            r_virt[IW'(w_idx)]  <= 1'b0;
                            r_rdy[IW'(w_idx)]   <= 1'b0;
                            r_bar[IW'(w_idx)]   <= w_bar;
                            r_esize[IW'(w_idx)] <= w_size;
                        end
                        K_ADDR: begin
                            if (r_valid[IW'(w_idx)]) begin
                                r_eaddr[IW'(w_idx)] <= w_addr;
                                r_known[IW'(w_idx)] <= 1'b1;
                                r_virt[IW'(w_idx)]  <= w_virt;
                            end
                        end
                        K_DATA: begin
                            if (r_valid[IW'(w_idx)]) begin
                                r_rdy[IW'(w_idx)] <= 1'b1;
                            end
                        end
                        K_FREE: begin
                            r_valid[IW'(w_idx)] <= 1'b0;
                            r_known[IW'(w_idx)] <= 1'b0;
                            r_virt[IW'(w_idx)]  <= 1'b0;
                            r_rdy[IW'(w_idx)]   <= 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (w_fin) begin
                r_busy <= 1'b0;
                r_last <= 1'b0;
            end else if (w_adv) begin
                // One entry per cycle; after the last cell of the last round the
                // token rests in the last cell until the output takes it.
                if (r_phase == PW'(CELLS - 1)) begin
                    r_phase <= '0;
                    if (r_round == RW'(ROUNDS - 1)) begin
                        r_last <= 1'b1;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_out};

    // A stalled result holds its value until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
    // The input side is closed during a search.
    a_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready) else $error("ready while busy");
    // A forward result names a valid-looking source only with status forward.
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out[1:0] != ST_FWD) |-> r_out[5:2] == 4'd0)
        else $error("source without forward");
endmodule

/* tb/sv/store_to_load_forward_search_tb.sv */
// Testbench for the store queue forwarding search: directed and random transactions.
`timescale 1ns / 1ps
module store_to_load_forward_search_tb;
    import stlf_pkg::*;

    localparam int NQ = 16;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: entry_index, access_address, access_size, barrier_flag,
    // address_is_virtual, older_store_mask, store_tail, zero fill.
    logic [95:0] s_axis_tdata;
    // tuser: kind.
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: status, source_entry, zero fill.
    logic [7:0]  m_axis_tdata;

    store_to_load_forward_search dut (.*);

    // Shadow copy of the store queue.
    logic        q_valid   [NQ];
    logic        q_known   [NQ];
    logic        q_virt    [NQ];
    logic        q_ready   [NQ];
    logic        q_barrier [NQ];
    logic [63:0] q_addr    [NQ];
    logic [1:0]  q_size    [NQ];

    typedef struct packed {
        t_status    status;
        logic [3:0] src;
    } t_fwd_result;

    t_fwd_result pending_results[$];
    int          mismatches = 0;
    longint      cycles = 0;
    int          stall_phase = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [14:0] lanes_of(logic [2:0] off, logic [1:0] sz);
        logic [7:0] b;
        b = 8'((16'd1 << (1 << sz)) - 1);
        return {7'b0, b} << off;
    endfunction

    // Walks the older valid stores youngest first, as the search does.
    function automatic t_fwd_result search_forward(logic [63:0] a, logic [1:0] sz,
                                                   logic [15:0] m, logic [3:0] y);
        t_fwd_result r;
        logic [14:0] ld, common;
        int i;
        r.status = ST_NONE;
        r.src = 4'd0;
        ld = lanes_of(a[2:0], sz);
        for (int age = 1; age <= NQ; age++) begin
            i = (int'(y) + NQ - age) % NQ;
            if (!m[i] || !q_valid[i]) continue;
            if (q_barrier[i]) begin
                r.status = ST_WAIT;
                return r;
            end
            if (!q_known[i] || q_virt[i]) continue;
            if (q_addr[i][63:3] != a[63:3]) continue;
            common = ld & lanes_of(q_addr[i][2:0], q_size[i]);
            if (common == 0) continue;
            if (common != ld || !q_ready[i]) begin
                r.status = ST_WAIT;
                return r;
            end
            r.status = ST_FWD;
            r.src = 4'(i);
            return r;
        end
        return r;
    endfunction

    function automatic void apply_item(logic [2:0] k, logic [3:0] idx, logic [63:0] a,
                                       logic [1:0] sz, logic bar, logic vir);
        case (k)
            K_ALLOC: begin
                q_valid[idx] = 1; q_known[idx] = 0; q_virt[idx] = 0; q_ready[idx] = 0;
                q_barrier[idx] = bar; q_size[idx] = sz;
            end
            K_ADDR: if (q_valid[idx]) begin
                q_addr[idx] = a; q_known[idx] = 1; q_virt[idx] = vir;
            end
            K_DATA: if (q_valid[idx]) q_ready[idx] = 1;
            K_FREE: begin
                q_valid[idx] = 0; q_known[idx] = 0; q_virt[idx] = 0; q_ready[idx] = 0;
            end
            default: ;
        endcase
    endfunction

    // Sender bursts: gap_left sets the idle gap, possibly none, before each burst.
    int burst_left, gap_left;

    task automatic send_item(logic [2:0] k, logic [3:0] idx, logic [63:0] a,
                             logic [1:0] sz, logic bar, logic vir,
                             logic [15:0] m, logic [3:0] y);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap_left) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {4'b0, y, m, vir, bar, sz, a, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // Accepted at this edge; the predictor runs in transaction order.
        if (k == K_LOOKUP) pending_results.push_back(search_forward(a, sz, m, y));
        else apply_item(k, idx, a, sz, bar, vir);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic lookup_rand(logic [63:0] a);
        send_item(K_LOOKUP, 4'($urandom), a, 2'($urandom), 1'($urandom), 1'($urandom),
                  16'($urandom), 4'($urandom));
    endtask

    // Result checker with its own stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    t_fwd_result e;
                    e = pending_results.pop_front();
                    if (m_axis_tdata[1:0] != e.status || m_axis_tdata[5:2] != e.src
                        || m_axis_tdata[7:6] != 2'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status %0d src %0d, got status %0d src %0d",
                                     e.status, e.src, m_axis_tdata[1:0], m_axis_tdata[5:2]);
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 16) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL store_to_load_forward_search");
            $finish;
        end
    end

    // Extremes, every kind, barrier, virtual, partial and unready cases.
    task automatic test_directed();
        send_item(K_LOOKUP, 0, 64'h0, 0, 0, 0, 16'hffff, 0);
        send_item(K_ALLOC, 4'd0, 64'h0, 2'd3, 1'b0, 1'b0, 0, 0);
        send_item(K_ADDR, 4'd0, 64'hffff_ffff_ffff_fff8, 0, 0, 1'b0, 0, 0);
        send_item(K_LOOKUP, 0, 64'hffff_ffff_ffff_fffc, 2'd2, 0, 0, 16'h0001, 4'd1);
        send_item(K_DATA, 4'd0, 0, 0, 0, 0, 0, 0);
        send_item(K_LOOKUP, 0, 64'hffff_ffff_ffff_fffc, 2'd2, 0, 0, 16'h0001, 4'd1);
        send_item(K_ALLOC, 4'd15, 0, 2'd0, 1'b0, 0, 0, 0);
        send_item(K_ADDR, 4'd15, 64'hffff_ffff_ffff_fffd, 0, 0, 0, 0, 0);
        send_item(K_DATA, 4'd15, 0, 0, 0, 0, 0, 0);
        send_item(K_LOOKUP, 0, 64'hffff_ffff_ffff_fffc, 2'd1, 0, 0, 16'h8001, 4'd0);
        send_item(K_LOOKUP, 0, 64'hffff_ffff_ffff_fffd, 2'd0, 0, 0, 16'h8001, 4'd0);
        send_item(K_ADDR, 4'd15, 64'hffff_ffff_ffff_fffd, 0, 0, 1'b1, 0, 0);
        send_item(K_LOOKUP, 0, 64'hffff_ffff_ffff_fffd, 2'd0, 0, 0, 16'h8001, 4'd0);
        send_item(K_ALLOC, 4'd7, 0, 0, 1'b1, 0, 0, 0);
        send_item(K_LOOKUP, 0, 64'h1234, 2'd3, 0, 0, 16'h0080, 4'd8);
        send_item(K_FREE, 4'd7, 0, 0, 0, 0, 0, 0);
        send_item(K_FREE, 4'd7, 0, 0, 0, 0, 0, 0);
        send_item(K_ADDR, 4'd7, 64'h5, 0, 0, 0, 0, 0);
        send_item(K_DATA, 4'd7, 0, 0, 0, 0, 0, 0);
        send_item(3'd5, 4'd1, 0, 0, 0, 0, 0, 0);
        send_item(3'd7, 4'd2, 0, 0, 0, 0, 0, 0);
        send_item(K_ALLOC, 4'd0, 0, 2'd1, 0, 0, 0, 0);
        send_item(K_LOOKUP, 0, 64'hffff_ffff_ffff_fffc, 2'd2, 0, 0, 16'hffff, 4'd15);
        go_idle();
    endtask

    // Random store queue updates and lookups on four doublewords plus random noise.
    task automatic test_random();
        logic [63:0] base [4];
        logic [3:0] e;
        for (int b = 0; b < 4; b++) base[b] = {$urandom, $urandom} & ~64'h7;
        for (int n = 0; n < 1700; n++) begin
            int pick;
            e = 4'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(K_ALLOC, e, 0, 2'($urandom), ($urandom_range(0, 9) == 0), 0, 0, 0);
            else if (pick < 27)
                send_item(K_ADDR, e, base[$urandom_range(0, 3)] | 64'($urandom_range(0, 7)),
                          0, 0, ($urandom_range(0, 7) == 0), 0, 0);
            else if (pick < 37)
                send_item(K_DATA, e, 0, 0, 0, 0, 0, 0);
            else if (pick < 45)
                send_item(K_FREE, e, 0, 0, 0, 0, 0, 0);
            else if (pick < 90)
                send_item(K_LOOKUP, 4'($urandom),
                          base[$urandom_range(0, 3)] | 64'($urandom_range(0, 7)),
                          2'($urandom), 0, 0, 16'($urandom), 4'($urandom));
            else if (pick < 95)
                lookup_rand({$urandom, $urandom});
            else
                send_item(3'($urandom_range(5, 7)), e, {$urandom, $urandom}, 2'($urandom),
                          1'($urandom), 1'($urandom), 16'($urandom), 4'($urandom));
        end
        go_idle();
    endtask

    initial begin
        burst_left = 0;
        for (int i = 0; i < NQ; i++) begin
            q_valid[i] = 0; q_known[i] = 0; q_virt[i] = 0; q_ready[i] = 0;
            q_barrier[i] = 0; q_addr[i] = 0; q_size[i] = 0;
        end
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS store_to_load_forward_search");
        else
            $display("FAIL store_to_load_forward_search");
        $finish;
    end
endmodule

/* store_to_load_forward_search.f */
hw/rtl/stlf_pkg.sv
hw/rtl/stlf_cell.sv
hw/rtl/store_to_load_forward_search.sv
tb/sv/store_to_load_forward_search_tb.sv
